// ----- sv/msfc_pkg.sv -----
// ----------------------------------------------------------------------------
// msfc_pkg
// Shared types and constants for the Modbus status frame checker: register
// indexes, reset values, frame constants, status codes and unit controls.
// ----------------------------------------------------------------------------
`default_nettype none

package msfc_pkg;

  // default frame geometry
  localparam int MAX_FRAME_DEF        = 32;
  localparam int COUNTER_OFFSET_DEF   = 11;
  localparam int DIRECTION_OFFSET_DEF = 12;

  // frame constants
  localparam int           MIN_FRAME_LEN   = 17;
  localparam logic [7:0]   FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]   EXP_BYTE_COUNT  = 8'h0C;
  localparam logic [15:0]  CRC_INIT        = 16'hFFFF;
  localparam logic [15:0]  CRC_POLY        = 16'hA001;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_CLOSED_LIMIT   = 3'd1;
  localparam logic [2:0] REG_CODE_OPENING   = 3'd2;
  localparam logic [2:0] REG_CODE_CLOSING   = 3'd3;
  localparam logic [2:0] REG_CODE_AT_LIMIT  = 3'd4;
  localparam logic [2:0] REG_CODE_AT_PED    = 3'd5;
  localparam logic [2:0] REG_CODE_STOPPED   = 3'd6;

  // configuration reset values
  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd10;
  localparam logic [7:0] CLOSED_LIMIT_RST   = 8'd15;
  localparam logic [7:0] CODE_RST           = 8'd0;

  // frame status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_HEADER  = 2'd1;
  localparam logic [1:0] STATUS_CRC     = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  // operation codes
  localparam logic [1:0] OP_IDLE    = 2'd0;
  localparam logic [1:0] OP_OPENING = 2'd1;
  localparam logic [1:0] OP_CLOSING = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_EVAL,
    ST_DIV,
    ST_WRITE
  } seq_state_t;

  // crc unit control and status
  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic zero;
  } crc_stat_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/msfc_crc_unit.sv -----
// ----------------------------------------------------------------------------
// msfc_crc_unit
// Bit-serial CRC-16/Modbus: folds one byte into the accumulator, then shifts
// one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_crc_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire msfc_pkg::crc_ctrl_t ctrl,
  input  wire logic [7:0]         data,
  output msfc_pkg::crc_stat_t     stat
);

  logic [15:0] crc_acc;
  logic [2:0]  bit_cnt;
  logic        busy;
  logic [15:0] crc_step;

  // one reflected shift step
  always_comb begin
    if (crc_acc[0]) begin
      crc_step = (crc_acc >> 1) ^ msfc_pkg::CRC_POLY;
    end else begin
      crc_step = crc_acc >> 1;
    end
  end

  // accumulator and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc <= msfc_pkg::CRC_INIT;
      bit_cnt <= '0;
      busy    <= 1'b0;
    end else if (ctrl.clear) begin
      crc_acc <= msfc_pkg::CRC_INIT;
      bit_cnt <= '0;
      busy    <= 1'b0;
    end else if (ctrl.start) begin
      crc_acc <= crc_acc ^ {8'h00, data};
      bit_cnt <= '0;
      busy    <= 1'b1;
    end else if (busy) begin
      crc_acc <= crc_step;
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.last = busy && (bit_cnt == 3'd7);
  assign stat.zero = (crc_acc == 16'h0000);

endmodule

`default_nettype wire

// ----- sv/msfc_div_unit.sv -----
// ----------------------------------------------------------------------------
// msfc_div_unit
// Restoring divider for the position: (512*diff + lim) / (2*lim), one
// quotient bit per cycle. Needs diff <= lim.
// ----------------------------------------------------------------------------
`default_nettype none

module msfc_div_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire msfc_pkg::div_ctrl_t ctrl,
  input  wire logic [7:0]          lim,
  input  wire logic [7:0]          diff,
  output msfc_pkg::div_stat_t      stat,
  output logic [8:0]               quotient
);

  logic [8:0] rem;
  logic [8:0] num_bits;
  logic [8:0] den;
  logic [3:0] step_cnt;
  logic       busy;
  logic [9:0] trial;
  logic       fits;

  // trial subtract
  always_comb begin
    trial = {rem, num_bits[8]};
    fits  = (trial >= {1'b0, den});
  end

  // divider registers; upper numerator bits preload the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
    end else if (ctrl.start) begin
      busy     <= 1'b1;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 4'd1;
      if (step_cnt == 4'd8) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= {1'b0, diff};
      num_bits <= {1'b0, lim};
      den      <= {lim, 1'b0};
      quotient <= '0;
    end else if (busy) begin
      num_bits <= {num_bits[7:0], 1'b0};
      if (fits) begin
        rem      <= 9'(trial - {1'b0, den});
        quotient <= {quotient[7:0], 1'b1};
      end else begin
        rem      <= trial[8:0];
        quotient <= {quotient[7:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.last = busy && (step_cnt == 4'd8);

endmodule

`default_nettype wire

// ----- sv/modbus_status_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_status_frame_checker_unit
// Checks Modbus RTU read-holding responses byte by byte, runs CRC-16/Modbus,
// and at frame end reports status, change flag, position and operation.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall  rx_byte, frame_end
//   out      send       out_valid/out_stall  frame_status, state_changed,
//                                            position_q8, operation
//   cfg      receive    cfg_write            cfg_index, cfg_data
//
// A counted byte is accepted and then shifted through the serial crc unit; a
// byte past MAX_FRAME is accepted without a crc step. A frame end byte adds an
// evaluate step, a divider run when the position is needed, and a load of the output register.
// in_stall is high whenever the sequencer is not idle.
// A stalled result holds in the output register; the next frame end waits
// until the register is free. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_status_frame_checker_unit #(
  parameter int MAX_FRAME        = msfc_pkg::MAX_FRAME_DEF,
  parameter int COUNTER_OFFSET   = msfc_pkg::COUNTER_OFFSET_DEF,
  parameter int DIRECTION_OFFSET = msfc_pkg::DIRECTION_OFFSET_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input bytes
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  // results
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      frame_status,
  output logic            state_changed,
  output logic [8:0]      position_q8,
  output logic [1:0]      operation,
  // configuration
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int BCW = $clog2(MAX_FRAME + 1);

  // configuration registers
  logic [7:0] device_address;
  logic [7:0] closed_limit_count;
  logic [7:0] code_opening;
  logic [7:0] code_closing;
  logic [7:0] code_at_limit;
  logic [7:0] code_at_pedestrian;
  logic [7:0] code_stopped;

  // frame state
  logic [BCW-1:0] byte_count;
  logic           header_good;
  logic [7:0]     frame_counter_byte;
  logic [7:0]     frame_direction_byte;
  logic [7:0]     prev_counter;
  logic [7:0]     prev_direction;
  logic           last_byte;

  // evaluated result
  logic [1:0] res_status;
  logic       res_changed;
  logic [1:0] res_op;
  logic       res_use_pos;

  msfc_pkg::seq_state_t state, state_next;
  msfc_pkg::crc_ctrl_t  crc_ctrl;
  msfc_pkg::crc_stat_t  crc_stat;
  msfc_pkg::div_ctrl_t  div_ctrl;
  msfc_pkg::div_stat_t  div_stat;
  logic [8:0]           div_quotient;

  logic           accept;
  logic           counted;
  logic           out_free;
  logic           hdr_bad;
  logic           dir_open;
  logic           dir_close;
  logic           dir_idle;
  logic           pos_needed;
  logic [7:0]     pos_diff;

  assign accept   = in_valid && !in_stall;
  assign counted  = (byte_count < BCW'(MAX_FRAME));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != msfc_pkg::ST_IDLE);

  // frame checks
  always_comb begin
    hdr_bad    = !header_good || (byte_count < BCW'(msfc_pkg::MIN_FRAME_LEN));
    dir_open   = (frame_direction_byte == code_opening);
    dir_close  = (frame_direction_byte == code_closing);
    dir_idle   = (frame_direction_byte == code_at_limit) ||
                 (frame_direction_byte == code_at_pedestrian) ||
                 (frame_direction_byte == code_stopped);
    pos_needed = (closed_limit_count != 8'd0) &&
                 (frame_counter_byte < closed_limit_count);
    pos_diff   = closed_limit_count - frame_counter_byte;
  end

  // shared units
  msfc_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .data (rx_byte),
    .stat (crc_stat)
  );

  msfc_div_unit u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .lim      (closed_limit_count),
    .diff     (pos_diff),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit controls
  always_comb begin
    state_next     = state;
    crc_ctrl.clear = 1'b0;
    crc_ctrl.start = 1'b0;
    div_ctrl.start = 1'b0;
    unique case (state)
      msfc_pkg::ST_IDLE: begin
        if (accept) begin
          crc_ctrl.start = counted;
          state_next     = msfc_pkg::ST_CRC;
        end
      end
      msfc_pkg::ST_CRC: begin
        if (!crc_stat.busy || crc_stat.last) begin
          state_next = last_byte ? msfc_pkg::ST_EVAL : msfc_pkg::ST_IDLE;
        end
      end
      msfc_pkg::ST_EVAL: begin
        if (!hdr_bad && crc_stat.zero && (dir_open || dir_close || dir_idle)
            && pos_needed) begin
          div_ctrl.start = 1'b1;
          state_next     = msfc_pkg::ST_DIV;
        end else begin
          state_next = msfc_pkg::ST_WRITE;
        end
      end
      msfc_pkg::ST_DIV: begin
        if (div_stat.last) begin
          state_next = msfc_pkg::ST_WRITE;
        end
      end
      msfc_pkg::ST_WRITE: begin
        if (out_free) begin
          crc_ctrl.clear = 1'b1;
          state_next     = msfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msfc_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address     <= msfc_pkg::DEVICE_ADDRESS_RST;
      closed_limit_count <= msfc_pkg::CLOSED_LIMIT_RST;
      code_opening       <= msfc_pkg::CODE_RST;
      code_closing       <= msfc_pkg::CODE_RST;
      code_at_limit      <= msfc_pkg::CODE_RST;
      code_at_pedestrian <= msfc_pkg::CODE_RST;
      code_stopped       <= msfc_pkg::CODE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msfc_pkg::REG_DEVICE_ADDRESS: device_address     <= cfg_data;
        msfc_pkg::REG_CLOSED_LIMIT:   closed_limit_count <= cfg_data;
        msfc_pkg::REG_CODE_OPENING:   code_opening       <= cfg_data;
        msfc_pkg::REG_CODE_CLOSING:   code_closing       <= cfg_data;
        msfc_pkg::REG_CODE_AT_LIMIT:  code_at_limit      <= cfg_data;
        msfc_pkg::REG_CODE_AT_PED:    code_at_pedestrian <= cfg_data;
        msfc_pkg::REG_CODE_STOPPED:   code_stopped       <= cfg_data;
        default: ;
      endcase
    end
  end

  // header checks, field capture and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count           <= '0;
      header_good          <= 1'b1;
      frame_counter_byte   <= '0;
      frame_direction_byte <= '0;
      last_byte            <= 1'b0;
    end else if (state == msfc_pkg::ST_WRITE && out_free) begin
      byte_count           <= '0;
      header_good          <= 1'b1;
      frame_counter_byte   <= '0;
      frame_direction_byte <= '0;
      last_byte            <= 1'b0;
    end else if (accept) begin
      last_byte <= frame_end;
      if (counted) begin
        byte_count <= byte_count + BCW'(1);
        if ((byte_count == BCW'(0)) && (rx_byte != device_address)) begin
          header_good <= 1'b0;
        end
        if ((byte_count == BCW'(1)) && (rx_byte != msfc_pkg::FC_READ_HOLDING)) begin
          header_good <= 1'b0;
        end
        if ((byte_count == BCW'(2)) && (rx_byte != msfc_pkg::EXP_BYTE_COUNT)) begin
          header_good <= 1'b0;
        end
        if (byte_count == BCW'(COUNTER_OFFSET)) begin
          frame_counter_byte <= rx_byte;
        end
        if (byte_count == BCW'(DIRECTION_OFFSET)) begin
          frame_direction_byte <= rx_byte;
        end
      end
    end
  end

  // frame evaluation and last good frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_counter   <= '0;
      prev_direction <= '0;
    end else if (state == msfc_pkg::ST_EVAL && !hdr_bad && crc_stat.zero) begin
      prev_counter   <= frame_counter_byte;
      prev_direction <= frame_direction_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (state == msfc_pkg::ST_EVAL) begin
      res_changed <= 1'b0;
      res_op      <= msfc_pkg::OP_IDLE;
      res_use_pos <= 1'b0;
      if (hdr_bad) begin
        res_status <= msfc_pkg::STATUS_HEADER;
      end else if (!crc_stat.zero) begin
        res_status <= msfc_pkg::STATUS_CRC;
      end else begin
        res_changed <= (frame_counter_byte != prev_counter) ||
                       (frame_direction_byte != prev_direction);
        if (dir_open || dir_close || dir_idle) begin
          res_status  <= msfc_pkg::STATUS_OK;
          res_use_pos <= pos_needed;
          if (dir_open) begin
            res_op <= msfc_pkg::OP_OPENING;
          end else if (dir_close) begin
            res_op <= msfc_pkg::OP_CLOSING;
          end
        end else begin
          res_status <= msfc_pkg::STATUS_UNKNOWN;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == msfc_pkg::ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == msfc_pkg::ST_WRITE && out_free) begin
      frame_status  <= res_status;
      state_changed <= res_changed;
      position_q8   <= res_use_pos ? div_quotient : 9'd0;
      operation     <= res_op;
    end
  end

  // checks
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == msfc_pkg::ST_IDLE) |-> (!crc_stat.busy && !div_stat.busy))
    else $error("shared unit busy while sequencer idle");

  a_pos_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (position_q8 != 9'd0)) |-> (frame_status == msfc_pkg::STATUS_OK))
    else $error("nonzero position on a faulty frame");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position_q8 <= 9'd256))
    else $error("position out of range");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == msfc_pkg::ST_WRITE))
    else $error("result appeared outside the write step");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == msfc_pkg::ST_DIV))
    else $error("divider running outside its step");

endmodule

`default_nettype wire
